FILE: design/udmd_pkg.sv
package udmd_pkg;

	// datapath width of the divisor and the magic multiplier
	localparam int WORD_BITS = 64;
	// width of the shift field and of the step counter
	localparam int SHIFT_W = 6;
	// last step index of the long division and of the shift search
	localparam logic [SHIFT_W-1:0] LAST_STEP = SHIFT_W'(WORD_BITS - 1);

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_SEARCH
	} state_t;

	// one restoring division step between sequencer and divide unit
	typedef struct packed {
		logic [WORD_BITS-1:0] rem;
		logic                 qbit;
	} div_step_t;

endpackage

FILE: design/udmd_div_unit.sv
module udmd_div_unit
	import udmd_pkg::*;
(
	input  logic [WORD_BITS-1:0] rem,
	input  logic [WORD_BITS-1:0] dvsr,
	output div_step_t            step
);

	logic [WORD_BITS:0] rem_dbl;
	logic [WORD_BITS:0] rem_sub;
	logic               ge;

	// double the remainder, trial subtract the divisor
	assign rem_dbl = {rem, 1'b0};
	assign rem_sub = rem_dbl - {1'b0, dvsr};
	assign ge      = (rem_dbl >= {1'b0, dvsr});

	// restore when the subtract would go negative
	always_comb begin
		step.qbit = ge;
		if (ge) begin
			step.rem = rem_sub[WORD_BITS-1:0];
		end else begin
			step.rem = rem_dbl[WORD_BITS-1:0];
		end
	end

endmodule

FILE: design/unsigned_division_magic_derivation.sv
// channel   signals                                   handshake
// -------   ---------------------------------------   ---------------------------
// command   start, divisor                            taken when start && !busy
// result    done, found, magic, shift_amount,         done pulses one cycle, the
//           increment_form                            fields are valid with it
//
// one divisor is screened in ST_CHECK, then ST_DIV runs the restoring division
// of 2^64 by the divisor, then ST_SEARCH tries shifts from 0 upward, one step each
// every step uses the single shared divide unit; a rejected divisor ends after screening;
// done rises in the same cycle as busy falls
// arst_n clears the sequencer and the done strobe at once
// the receiver cannot stall: each result is shown for exactly one cycle
module unsigned_division_magic_derivation
	import udmd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [WORD_BITS-1:0] divisor,
	output logic                 done,
	output logic                 found,
	output logic [WORD_BITS-1:0] magic,
	output logic [SHIFT_W-1:0]   shift_amount,
	output logic                 increment_form
);

	state_t               state_q, state_d;
	logic [WORD_BITS-1:0] d_q, d_d;
	logic [WORD_BITS-1:0] rem_q, rem_d;
	logic [WORD_BITS-1:0] quo_q, quo_d;
	logic                 qc_q, qc_d;
	logic [WORD_BITS-1:0] pow_q, pow_d;
	logic [SHIFT_W-1:0]   cnt_q, cnt_d;

	logic                 done_q, done_d;
	logic                 found_q, found_d;
	logic [WORD_BITS-1:0] magic_q, magic_d;
	logic [SHIFT_W-1:0]   shift_q, shift_d;
	logic                 incr_q, incr_d;

	div_step_t            step;
	logic [WORD_BITS:0]   err_bound;
	logic                 fit_hit;
	logic                 incr_hit;
	logic                 reject;
	logic [WORD_BITS-1:0] quo_inc;

	// shared divide step
	udmd_div_unit u_div (
		.rem  (rem_q),
		.dvsr (d_q),
		.step (step)
	);

	// fitting test d - r <= 2^s written as d <= r + 2^s
	assign err_bound = {1'b0, rem_q} + {1'b0, pow_q};
	assign fit_hit   = ({1'b0, d_q} <= err_bound);
	assign incr_hit  = qc_q || (&quo_q);
	assign quo_inc   = quo_q + WORD_BITS'(1);

	// divisors below 3 and powers of two are rejected
	assign reject = (d_q < WORD_BITS'(3)) || ((d_q & (d_q - WORD_BITS'(1))) == '0);

	// sequencer next state and datapath control
	always_comb begin
		state_d = state_q;
		d_d     = d_q;
		rem_d   = rem_q;
		quo_d   = quo_q;
		qc_d    = qc_q;
		pow_d   = pow_q;
		cnt_d   = cnt_q;
		done_d  = 1'b0;
		found_d = found_q;
		magic_d = magic_q;
		shift_d = shift_q;
		incr_d  = incr_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					d_d     = divisor;
					rem_d   = WORD_BITS'(1);
					quo_d   = '0;
					qc_d    = 1'b0;
					cnt_d   = '0;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (reject) begin
					done_d  = 1'b1;
					found_d = 1'b0;
					magic_d = '0;
					shift_d = '0;
					incr_d  = 1'b0;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				rem_d = step.rem;
				quo_d = {quo_q[WORD_BITS-2:0], step.qbit};
				cnt_d = cnt_q + SHIFT_W'(1);
				if (cnt_q == LAST_STEP) begin
					pow_d   = WORD_BITS'(1);
					qc_d    = 1'b0;
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (incr_hit || fit_hit) begin
					done_d  = 1'b1;
					found_d = 1'b1;
					magic_d = quo_inc;
					shift_d = cnt_q;
					incr_d  = incr_hit;
					state_d = ST_IDLE;
				end else begin
					rem_d = step.rem;
					quo_d = {quo_q[WORD_BITS-2:0], step.qbit};
					qc_d  = quo_q[WORD_BITS-1];
					pow_d = {pow_q[WORD_BITS-2:0], 1'b0};
					cnt_d = cnt_q + SHIFT_W'(1);
					if (cnt_q == LAST_STEP) begin
						done_d  = 1'b1;
						found_d = 1'b0;
						magic_d = '0;
						shift_d = '0;
						incr_d  = 1'b0;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	// datapath and result registers
	always_ff @(posedge clk) begin
		d_q     <= d_d;
		rem_q   <= rem_d;
		quo_q   <= quo_d;
		qc_q    <= qc_d;
		pow_q   <= pow_d;
		cnt_q   <= cnt_d;
		found_q <= found_d;
		magic_q <= magic_d;
		shift_q <= shift_d;
		incr_q  <= incr_d;
	end

	// port drive
	assign busy           = (state_q != ST_IDLE);
	assign done           = done_q;
	assign found          = found_q;
	assign magic          = magic_q;
	assign shift_amount   = shift_q;
	assign increment_form = incr_q;

`ifndef SYNTHESIS
	// a finished transaction leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer busy");

	// an accepted command always starts work
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not start the sequencer");

	// a result without a magic carries all-zero fields
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (magic == '0 && shift_amount == '0 && !increment_form))
		else $error("rejected result with non-zero fields");

	// the error bound holds exactly one set bit during the search
	a_pow_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> $onehot(pow_q))
		else $error("shift bound lost its single bit");

	// the partial remainder stays below the divisor during the search
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (rem_q < d_q))
		else $error("remainder not below divisor");
`endif

endmodule
